/* hdl/srb_pkg.sv */
package srb_pkg;

  localparam int WINDOW = 32;

  typedef enum logic [3:0] {
    ST_RELEASED = 4'd0,
    ST_CLOSED   = 4'd1,
    ST_MISSING  = 4'd2,
    ST_INVALID  = 4'd3,
    ST_DUP      = 4'd4,
    ST_TERM     = 4'd5,
    ST_GAP      = 4'd6,
    ST_CAPACITY = 4'd7,
    ST_BUFFERED = 4'd8,
    ST_TIMER    = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    REG_MAX_EVENTS  = 3'd0,
    REG_MAX_BYTES   = 3'd1,
    REG_MAX_GAP     = 3'd2,
    REG_GAP_TIMEOUT = 3'd3,
    REG_SEQ_REQ     = 3'd4,
    REG_CLOSED      = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DRAIN
  } back_state_t;

endpackage

/* hdl/srb_queue.sv */
module srb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wptr] <= in_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wptr <= ~wptr;
      end
      if (out_valid && out_ready) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

/* hdl/srb_back.sv */
module srb_back #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [5:0]                 max_events,
  input  logic [31:0]                max_bytes,
  input  logic [5:0]                 max_gap,
  input  logic [47:0]                gap_timeout,
  input  logic                       sequence_required,
  input  logic                       closed_mode,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic [147+PAYLOAD_WIDTH-1:0] cmd_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [3:0]                 res_status,
  output logic [PAYLOAD_WIDTH-1:0]   res_payload,
  output logic [63:0]                res_sequence,
  output logic                       res_last,
  output logic                       res_expired
);

  localparam int IW = $clog2(srb_pkg::WINDOW);
  localparam int CW = $clog2(srb_pkg::WINDOW + 1);

  logic                     op, has_seq, term;
  logic [63:0]              seq;
  logic [31:0]              bytes;
  logic [PAYLOAD_WIDTH-1:0] pay;
  logic [47:0]              now;

  assign {now, pay, bytes, term, seq, has_seq, op} = cmd_data;

  logic [srb_pkg::WINDOW-1:0] slot_valid;
  logic [PAYLOAD_WIDTH-1:0] slot_payload [srb_pkg::WINDOW];
  logic [31:0]              slot_bytes [srb_pkg::WINDOW];
  logic [63:0]              next_expected;
  logic                     terminal_known;
  logic [63:0]              terminal_sequence;
  logic                     gap_open;
  logic [47:0]              gap_start;
  logic [CW-1:0]            waiting_count;
  logic [31:0]              waiting_bytes;

  srb_pkg::back_state_t state, state_next;

  logic          out_full;
  logic [3:0]    o_status;
  logic [PAYLOAD_WIDTH-1:0] o_pay;
  logic [63:0]   o_seq;
  logic          o_last, o_exp;

  assign res_valid    = out_full;
  assign res_status   = o_status;
  assign res_payload  = o_pay;
  assign res_sequence = o_seq;
  assign res_last     = o_last;
  assign res_expired  = o_exp;

  logic out_free;
  assign out_free = !out_full || res_ready;

  logic [63:0] ahead;
  logic [6:0]  gap_lim;
  logic        later;
  logic [IW-1:0] slot, base, drain_slot, succ_slot;
  logic        succ_valid;
  logic [31:0] room;
  logic [47:0] elapsed;
  logic        take;
  logic        drain_step;
  logic        load;
  srb_pkg::status_t rej;
  logic        do_buf, do_rel, do_pass;

  srb_pkg::status_t         r_status;
  logic [PAYLOAD_WIDTH-1:0] r_pay;
  logic [63:0]              r_seq;
  logic                     r_last, r_exp;

  assign ahead   = seq - next_expected;
  assign gap_lim = (max_gap < 6'(srb_pkg::WINDOW)) ? {1'b0, max_gap} : 7'(srb_pkg::WINDOW);
  assign slot    = seq[IW-1:0];
  assign base    = next_expected[IW-1:0];
  assign drain_slot = base;
  assign succ_slot  = drain_slot + IW'(1);
  assign succ_valid = slot_valid[succ_slot];
  assign room    = (waiting_bytes < max_bytes) ? max_bytes - waiting_bytes : 32'd0;
  assign elapsed = now - gap_start;
  assign drain_step = (state == srb_pkg::BK_DRAIN) && out_free;
  assign load       = take || drain_step;

  always_comb begin
    logic [IW:0] d;
    later = 1'b0;
    for (int i = 0; i < srb_pkg::WINDOW; i++) begin
      d = {1'b0, IW'(i) - base};
      if (d == '0) d = (IW+1)'(srb_pkg::WINDOW);
      if (slot_valid[i] && 64'(d) > ahead) later = 1'b1;
    end
  end

  always_comb begin
    rej = srb_pkg::ST_BUFFERED;
    do_buf = 1'b0; do_rel = 1'b0; do_pass = 1'b0;
    if (closed_mode) rej = srb_pkg::ST_CLOSED;
    else if (!has_seq) begin
      if (sequence_required) rej = srb_pkg::ST_MISSING;
      else do_pass = 1'b1;
    end else if (seq == '1) rej = srb_pkg::ST_INVALID;
    else if (seq < next_expected) rej = srb_pkg::ST_DUP;
    else if (terminal_known && seq > terminal_sequence) rej = srb_pkg::ST_TERM;
    else if (term && terminal_known && seq != terminal_sequence) rej = srb_pkg::ST_TERM;
    else if (term && later) rej = srb_pkg::ST_TERM;
    else if (ahead > 64'(gap_lim)) rej = srb_pkg::ST_GAP;
    else if (ahead != '0 && slot_valid[slot]) rej = srb_pkg::ST_DUP;
    else if (ahead != '0) begin
      if (32'(waiting_count) >= 32'(max_events) || bytes > room) rej = srb_pkg::ST_CAPACITY;
      else do_buf = 1'b1;
    end else do_rel = 1'b1;
  end

  always_comb begin
    r_status = rej;
    r_pay    = '0;
    r_seq    = '0;
    r_last   = 1'b1;
    r_exp    = 1'b0;
    if (op) begin
      r_status = srb_pkg::ST_TIMER;
      r_exp    = waiting_count != '0 && gap_open && now >= gap_start &&
                 elapsed >= gap_timeout;
    end else if (do_pass) begin
      r_status = srb_pkg::ST_RELEASED;
      r_pay    = pay;
    end else if (do_rel) begin
      r_status = srb_pkg::ST_RELEASED;
      r_pay    = pay;
      r_seq    = seq;
      r_last   = !succ_valid;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    take       = 1'b0;
    case (state)
      srb_pkg::BK_IDLE: begin
        cmd_ready = out_free;
        take      = cmd_valid && out_free;
        if (take && !op && do_rel && succ_valid) state_next = srb_pkg::BK_DRAIN;
      end
      srb_pkg::BK_DRAIN: begin
        if (out_free && !succ_valid) state_next = srb_pkg::BK_IDLE;
      end
      default: state_next = srb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srb_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      o_status <= srb_pkg::ST_RELEASED;
      o_pay    <= slot_payload[drain_slot];
      o_seq    <= next_expected;
      o_last   <= !succ_valid;
      o_exp    <= 1'b0;
    end else if (take) begin
      o_status <= r_status;
      o_pay    <= r_pay;
      o_seq    <= r_seq;
      o_last   <= r_last;
      o_exp    <= r_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      slot_valid <= '0;
      next_expected <= '0;
      terminal_known <= 1'b0;
      terminal_sequence <= '0;
      gap_open <= 1'b0;
      gap_start <= '0;
      waiting_count <= '0;
      waiting_bytes <= '0;
    end else begin
      if (load) out_full <= 1'b1;
      else if (res_ready) out_full <= 1'b0;
      if (take && !op && do_rel) begin
        if (term) begin
          terminal_known <= 1'b1; terminal_sequence <= seq;
        end
        next_expected <= next_expected + 64'd1;
        if (!succ_valid && waiting_count == '0) gap_open <= 1'b0;
      end else if (take && !op && do_buf) begin
        if (term) begin
          terminal_known <= 1'b1; terminal_sequence <= seq;
        end
        if (!gap_open) begin
          gap_open <= 1'b1; gap_start <= now;
        end
        waiting_bytes <= waiting_bytes + bytes;
        waiting_count <= waiting_count + CW'(1);
        slot_valid[slot] <= 1'b1;
        slot_payload[slot] <= pay;
        slot_bytes[slot] <= bytes;
      end else if (drain_step) begin
        slot_valid[drain_slot] <= 1'b0;
        waiting_bytes <= waiting_bytes - slot_bytes[drain_slot];
        waiting_count <= waiting_count - CW'(1);
        next_expected <= next_expected + 64'd1;
        if (!succ_valid && waiting_count == CW'(1)) gap_open <= 1'b0;
      end
    end
  end

endmodule

/* hdl/sequence_reorder_buffer.sv */
// Path: an accepted item enters the two-entry input queue; its first result is
// then registered by the back end when it is idle and its result register is free.
// Throughput: one item per cycle while results are taken and no drain runs; a
// release drains buffered successors one slot per cycle while results are taken.
// Reset: synchronous active-high rst empties the window and the queue and
// restores the control and configuration registers; stored data is not cleared.
module sequence_reorder_buffer #(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // has_sequence, sequence, is_terminal, byte_size, payload, now, zero fill
  input  logic [((146+PAYLOAD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_payload, out_sequence, expired, zero fill
  output logic [((65+PAYLOAD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [3:0]  m_axis_tuser,
  // last
  output logic        m_axis_tlast
);

  localparam int CMD_W = 147 + PAYLOAD_WIDTH;
  localparam int OUT_W = 65 + PAYLOAD_WIDTH;
  localparam int OUT_BW = ((OUT_W + 7) / 8) * 8;

  logic [5:0]  max_events, max_gap;
  logic [31:0] max_bytes;
  logic [47:0] gap_timeout;
  logic        sequence_required, closed_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_events <= 6'd32;
      max_bytes <= 32'd65536;
      max_gap <= 6'd32;
      gap_timeout <= 48'd1000;
      sequence_required <= 1'b0;
      closed_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        srb_pkg::REG_MAX_EVENTS:  max_events <= cfg_data[5:0];
        srb_pkg::REG_MAX_BYTES:   max_bytes <= cfg_data[31:0];
        srb_pkg::REG_MAX_GAP:     max_gap <= cfg_data[5:0];
        srb_pkg::REG_GAP_TIMEOUT: gap_timeout <= cfg_data;
        srb_pkg::REG_SEQ_REQ:     sequence_required <= cfg_data[0];
        srb_pkg::REG_CLOSED:      closed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CMD_W-1:0] cmd;
  logic             q_valid, q_ready;
  logic [CMD_W-1:0] q_data;

  assign cmd = {s_axis_tdata[CMD_W-2:0], s_axis_tuser};

  srb_queue #(.WIDTH(CMD_W)) u_queue (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  logic [PAYLOAD_WIDTH-1:0] op_pay;
  logic [63:0]              op_seq;
  logic                     op_exp;

  srb_back #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_back (
    .clk, .rst,
    .max_events, .max_bytes, .max_gap, .gap_timeout, .sequence_required, .closed_mode,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_status(m_axis_tuser), .res_payload(op_pay), .res_sequence(op_seq),
    .res_last(m_axis_tlast), .res_expired(op_exp)
  );

  assign m_axis_tdata = OUT_BW'({op_exp, op_seq, op_pay});

endmodule

/* hdl/srb_checker.sv */
module srb_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != srb_pkg::ST_RELEASED |-> m_axis_tlast)
    else $error("rejection not marked last");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= srb_pkg::ST_TIMER)
    else $error("status code out of range");

endmodule

bind sequence_reorder_buffer srb_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
